// ----- hdl/r5rm_pkg.sv -----
// shared constants for the raid5 read mapper: widths, defaults, register indexes
`default_nettype none

package r5rm_pkg;

    // default sizes handed to the top level
    localparam int BLOCK_BITS_DEF  = 40;
    localparam int CACHE_SLOTS_DEF = 64;

    // disk geometry
    localparam int MIN_DISKS = 3;
    localparam int MAX_DISKS = 16;
    localparam int DISK_W    = 4;   // disk index width
    localparam int DCNT_W    = 5;   // disk count width

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_VALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_DISK  = 2'd2;

    localparam logic [DCNT_W-1:0] DISK_COUNT_RST = 5'd3;

endpackage

`default_nettype wire

// ----- hdl/raid5_read_mapper_with_tag_cache.sv -----
// raid5 read mapper: bit-serial stripe mapping plus direct-mapped tag cache
// a result passes the serial divide, the cache read and the tag compare before it is valid;
// one item at a time: no new item is taken until the bit-serial divider is through with the last,
//   but a new item is taken while the previous result still waits in the output register
// reset: synchronous active low; a clearing pass over all CACHE_SLOTS slots then zeroes
//   the valid memory, no item is accepted during it (config writes are taken)
`default_nettype none

module raid5_read_mapper_with_tag_cache #(
    parameter int BLOCK_BITS  = r5rm_pkg::BLOCK_BITS_DEF,
    parameter int CACHE_SLOTS = r5rm_pkg::CACHE_SLOTS_DEF,
    localparam int SLOT_W     = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,

    // configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [r5rm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [r5rm_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // request channel
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [BLOCK_BITS-1:0]           i_logical_block,

    // result channel
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_cache_hit,
    output logic [SLOT_W-1:0]               o_cache_slot,
    output logic [BLOCK_BITS-2:0]           o_stripe_row,
    output logic [r5rm_pkg::DISK_W-1:0]     o_target_disk,
    output logic [r5rm_pkg::DISK_W-1:0]     o_parity_disk,
    output logic                            o_rebuild
);

    localparam int DISK_W = r5rm_pkg::DISK_W;
    localparam int DCNT_W = r5rm_pkg::DCNT_W;
    localparam int CNT_W  = $clog2(BLOCK_BITS);

    // sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;   // sweeping the valid memory
    localparam logic [2:0] S_IDLE  = 3'd1;   // waiting for an item
    localparam logic [2:0] S_RUN   = 3'd2;   // one block bit per cycle
    localparam logic [2:0] S_READ  = 3'd3;   // cache read issued
    localparam logic [2:0] S_CMP   = 3'd4;   // tag compare, update, hand over

    // control state
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;
    logic              r_out_valid, n_out_valid;

    // configuration registers
    logic [DCNT_W-1:0] r_disk_count;
    logic              r_missing_valid;
    logic [DISK_W-1:0] r_missing_disk;

    // datapath registers
    logic [BLOCK_BITS-1:0] r_blk;      // block bits out at the top, quotient bits in below
    logic [BLOCK_BITS-1:0] r_tag;      // untouched copy of the block for the cache
    logic [DISK_W-1:0]     r_trem;     // block mod (disks - 1)
    logic [DISK_W-1:0]     r_prem;     // row mod disks, built from the quotient bits
    logic [SLOT_W-1:0]     r_srem;     // block mod slot count
    logic [DISK_W-1:0]     r_div_m1;   // disks - 1, latched per item
    logic [DCNT_W-1:0]     r_ndisk;    // disks, latched per item

    // cache memories
    logic [BLOCK_BITS-1:0] r_tag_mem [CACHE_SLOTS];
    logic                  r_vld_mem [CACHE_SLOTS];
    logic [BLOCK_BITS-1:0] r_tag_rd;
    logic                  r_vld_rd;

    // result registers
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot_o;
    logic [BLOCK_BITS-2:0] r_row_o;
    logic [DISK_W-1:0]     r_target_o;
    logic [DISK_W-1:0]     r_parity_o;
    logic                  r_rebuild_o;

    // combinational helpers
    logic                  in_fire;
    logic                  out_free;
    logic                  cmp_fire;
    logic [DCNT_W-1:0]     used_disks;
    logic                  bit_in;
    logic [DISK_W:0]       t_sh;
    logic                  q_bit;
    logic [DISK_W:0]       t_nx;
    logic [DISK_W:0]       p_sh;
    logic [DISK_W:0]       p_nx;
    logic [SLOT_W:0]       s_sh;
    logic [SLOT_W:0]       s_nx;
    logic [DISK_W-1:0]     target;
    logic                  hit;
    logic                  vld_we;
    logic [SLOT_W-1:0]     vld_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cmp_fire    = (r_state == S_CMP) && out_free;

    // disk count held inside the supported range
    always_comb begin
        if (r_disk_count < DCNT_W'(r5rm_pkg::MIN_DISKS)) begin
            used_disks = DCNT_W'(r5rm_pkg::MIN_DISKS);
        end else if (r_disk_count > DCNT_W'(r5rm_pkg::MAX_DISKS)) begin
            used_disks = DCNT_W'(r5rm_pkg::MAX_DISKS);
        end else begin
            used_disks = r_disk_count;
        end
    end

    // one restoring step of each remainder per cycle
    always_comb begin
        bit_in = r_blk[BLOCK_BITS-1];
        t_sh   = {r_trem, bit_in};
        q_bit  = (t_sh >= {1'b0, r_div_m1});
        t_nx   = q_bit ? (t_sh - {1'b0, r_div_m1}) : t_sh;
        // the quotient bit is the next bit of the row, so fold it into row mod disks
        p_sh   = {r_prem, q_bit};
        p_nx   = (p_sh >= (DISK_W+1)'(r_ndisk)) ? (p_sh - (DISK_W+1)'(r_ndisk)) : p_sh;
        s_sh   = {r_srem, bit_in};
        s_nx   = (s_sh >= (SLOT_W+1)'(CACHE_SLOTS)) ? (s_sh - (SLOT_W+1)'(CACHE_SLOTS))
                                                     : s_sh;
    end

    // data disk skips over the parity disk
    assign target = (r_trem >= r_prem) ? (r_trem + DISK_W'(1)) : r_trem;
    assign hit    = r_vld_rd && (r_tag_rd == r_tag);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + SLOT_W'(1);
                if (r_clr_idx == SLOT_W'(CACHE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state   = S_RUN;
                    n_bit_cnt = CNT_W'(BLOCK_BITS - 1);
                end
            end
            S_RUN: begin
                n_bit_cnt = r_bit_cnt - CNT_W'(1);
                if (r_bit_cnt == '0) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_bit_cnt   <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_cnt   <= n_bit_cnt;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_count    <= r5rm_pkg::DISK_COUNT_RST;
            r_missing_valid <= 1'b0;
            r_missing_disk  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                r5rm_pkg::REG_DISK_COUNT:    r_disk_count    <= i_cfg_data[DCNT_W-1:0];
                r5rm_pkg::REG_MISSING_VALID: r_missing_valid <= i_cfg_data[0];
                r5rm_pkg::REG_MISSING_DISK:  r_missing_disk  <= i_cfg_data[DISK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_blk    <= i_logical_block;
            r_tag    <= i_logical_block;
            r_trem   <= '0;
            r_prem   <= '0;
            r_srem   <= '0;
            r_div_m1 <= DISK_W'(used_disks - DCNT_W'(1));
            r_ndisk  <= used_disks;
        end else if (r_state == S_RUN) begin
            r_blk  <= {r_blk[BLOCK_BITS-2:0], q_bit};
            r_trem <= t_nx[DISK_W-1:0];
            r_prem <= p_nx[DISK_W-1:0];
            r_srem <= s_nx[SLOT_W-1:0];
        end
    end

    // tag memory: written on a miss only, never cleared
    always_ff @(posedge i_clk) begin
        if (cmp_fire && !hit) begin
            r_tag_mem[r_srem] <= r_tag;
        end
        r_tag_rd <= r_tag_mem[r_srem];
    end

    // valid memory: cleared by the sweep, set on a miss
    assign vld_we   = (r_state == S_CLEAR) || (cmp_fire && !hit);
    assign vld_addr = (r_state == S_CLEAR) ? r_clr_idx : r_srem;

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            r_vld_mem[vld_addr] <= (r_state != S_CLEAR);
        end
        r_vld_rd <= r_vld_mem[r_srem];
    end

    // result register, loaded when the previous result has gone or is being taken
    always_ff @(posedge i_clk) begin
        if (cmp_fire) begin
            r_hit       <= hit;
            r_slot_o    <= r_srem;
            r_row_o     <= r_blk[BLOCK_BITS-2:0];
            r_target_o  <= target;
            r_parity_o  <= r_prem;
            r_rebuild_o <= r_missing_valid && (target == r_missing_disk);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cache_hit   = r_hit;
    assign o_cache_slot  = r_slot_o;
    assign o_stripe_row  = r_row_o;
    assign o_target_disk = r_target_o;
    assign o_parity_disk = r_parity_o;
    assign o_rebuild     = r_rebuild_o;

    // a fresh item always starts a full pass over the block bits
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_RUN) && (r_bit_cnt == CNT_W'(BLOCK_BITS - 1)))
        else $error("serial pass did not start after an accepted item");

    // remainders stay below their divisors once the pass is over
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_trem < r_div_m1) && ({1'b0, r_prem} < r_ndisk)
                                && ((SLOT_W+1)'(r_srem) < (SLOT_W+1)'(CACHE_SLOTS)))
        else $error("remainder out of range at end of serial pass");

    // a result only appears out of the compare step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_CMP))
        else $error("result raised outside the compare step");

endmodule

`default_nettype wire
